FILE: rtl/pzsf_pkg.sv
// ---------------------------------------------------------------------------
// pzsf_pkg
// Shared types and constants of the zlib stored-stream framer.
// ---------------------------------------------------------------------------
package pzsf_pkg;

    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int HGT_W      = 15;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [HGT_W-1:0] HEIGHT_CAP  = 15'd16384;
    localparam logic [7:0]       ZLIB_CMF    = 8'h78;
    localparam logic [7:0]       ZLIB_FLG    = 8'h01;
    localparam logic [16:0]      ADLER_MOD   = 17'd65521;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 4'd11;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eos;
    } res_t;

endpackage

FILE: rtl/png_zlib_stored_stream_framer.sv
// ---------------------------------------------------------------------------
// png_zlib_stored_stream_framer
// Wraps an RGB raster byte stream as a zlib stream of stored blocks.
// ---------------------------------------------------------------------------
// Each RGB byte taken on s_ produces the stream bytes it causes on m_: its
// data byte plus any inserted bytes (2 for the zlib header at the start of
// the image, 1 for the row filter byte, 5 for each stored-block header, 4 for
// the Adler-32 trailer after the last byte). With full-size blocks an item
// therefore causes at most 10 bytes; with blocks short enough for two block
// headers to fall in one item it can cause up to 14, but only the first 11
// of an item are put out and the rest are lost. A dropped item puts out none.
// The sequencer moves one stream byte a cycle, while the output queue has
// space, into a two-entry output queue; a full queue stalls it. A new item
// is taken in the cycle the last byte of the previous one is produced.
// m_tlast marks the last byte put out for an item, m_tuser the last trailer
// byte. Inputs after the image is complete are taken and dropped. Write
// image_width and image_height before the first byte; once the stream has
// begun they are frozen until reset.
// ---------------------------------------------------------------------------
module png_zlib_stored_stream_framer #(
    parameter int MAX_WIDTH = 16384,
    parameter int BLOCK_LEN = 65535
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rgb_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,
    output logic                             m_tuser,   // [0] end_of_stream
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pzsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pzsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int RB_W  = $clog2(3 * MAX_WIDTH + 1);
    localparam int TOT_W = $clog2(16384 * (3 * MAX_WIDTH + 1) + 1);

    logic [RB_W-1:0]  row_len;
    logic [TOT_W-1:0] total_bytes;
    logic             frozen;
    logic             space;
    logic             push;
    pzsf_pkg::res_t   push_res;
    pzsf_pkg::res_t   m_res;

    pzsf_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .RB_W      (RB_W),
        .TOT_W     (TOT_W)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .frozen      (frozen),
        .row_len     (row_len),
        .total_bytes (total_bytes)
    );

    pzsf_seq #(
        .BLOCK_LEN (BLOCK_LEN),
        .RB_W      (RB_W),
        .TOT_W     (TOT_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .row_len     (row_len),
        .total_bytes (total_bytes),
        .frozen      (frozen),
        .space       (space),
        .push        (push),
        .push_res    (push_res)
    );

    pzsf_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .space    (space),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = m_res.data;
    assign m_tlast = m_res.last;
    assign m_tuser = m_res.eos;

endmodule

FILE: rtl/pzsf_cfg.sv
// ---------------------------------------------------------------------------
// pzsf_cfg
// Image size registers, clamped on write and frozen once a stream has begun.
// ---------------------------------------------------------------------------
module pzsf_cfg #(
    parameter int MAX_WIDTH = 16384,
    parameter int RB_W      = 16,
    parameter int TOT_W     = 30
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pzsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pzsf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             frozen,
    output logic [RB_W-1:0]                  row_len,
    output logic [TOT_W-1:0]                 total_bytes
);

    localparam logic [pzsf_pkg::CFG_DATA_W-1:0] WIDTH_CAP =
        pzsf_pkg::CFG_DATA_W'(MAX_WIDTH);

    logic [pzsf_pkg::HGT_W-1:0]      h_eff_reg;
    logic [pzsf_pkg::HGT_W-1:0]      h_eff_next;
    logic [RB_W-1:0]                 row_len_reg;
    logic [RB_W-1:0]                 row_len_next;
    logic [pzsf_pkg::CFG_DATA_W-1:0] w_clamped;
    logic                            wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && !frozen;

    always_comb begin
        if (cfg_data == '0) begin
            w_clamped = pzsf_pkg::CFG_DATA_W'(1);
        end else if (cfg_data > WIDTH_CAP) begin
            w_clamped = WIDTH_CAP;
        end else begin
            w_clamped = cfg_data;
        end
    end

    always_comb begin
        h_eff_next   = h_eff_reg;
        row_len_next = row_len_reg;
        if (wr_en && cfg_index == pzsf_pkg::REG_WIDTH) begin
            row_len_next = RB_W'(3 * int'(w_clamped));
        end
        if (wr_en && cfg_index == pzsf_pkg::REG_HEIGHT) begin
            if (cfg_data == '0) begin
                h_eff_next = pzsf_pkg::HGT_W'(1);
            end else if (cfg_data > pzsf_pkg::HEIGHT_CAP) begin
                h_eff_next = pzsf_pkg::HEIGHT_CAP;
            end else begin
                h_eff_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_eff_reg   <= pzsf_pkg::HGT_W'(1);
            row_len_reg <= RB_W'(3);
        end else begin
            h_eff_reg   <= h_eff_next;
            row_len_reg <= row_len_next;
        end
    end

    // raw stream length: height * (filter byte + row bytes)
    assign row_len     = row_len_reg;
    assign total_bytes = TOT_W'(TOT_W'(h_eff_reg) * TOT_W'(row_len_reg))
                       + TOT_W'(h_eff_reg);

endmodule

FILE: rtl/pzsf_outq.sv
// ---------------------------------------------------------------------------
// pzsf_outq
// Two-entry result queue that decouples the sequencer from the output side.
// ---------------------------------------------------------------------------
module pzsf_outq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pzsf_pkg::res_t   push_res,
    output logic             space,
    output logic             m_valid,
    input  logic             m_ready,
    output pzsf_pkg::res_t   m_res
);

    pzsf_pkg::res_t q_mem [2];
    logic           wptr_reg;
    logic           wptr_next;
    logic           rptr_reg;
    logic           rptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           pop;

    assign space   = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_res   = q_mem[rptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: rtl/pzsf_seq.sv
// ---------------------------------------------------------------------------
// pzsf_seq
// Per-item sequencer: zlib header, stored-block headers, filter and data
// bytes, running Adler-32 and the trailer, one stream byte per step.
// ---------------------------------------------------------------------------
module pzsf_seq #(
    parameter int BLOCK_LEN = 65535,
    parameter int RB_W      = 16,
    parameter int TOT_W     = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic [RB_W-1:0]      row_len,
    input  logic [TOT_W-1:0]     total_bytes,
    output logic                 frozen,
    input  logic                 space,
    output logic                 push,
    output pzsf_pkg::res_t       push_res
);

    localparam int LW = pzsf_pkg::LEN_W;
    localparam logic [LW-1:0] BLK_MAX = LW'(BLOCK_LEN);

    typedef enum logic [3:0] {
        P_IDLE, P_ZH0, P_ZH1, P_BH0, P_BH1, P_BH2, P_BH3, P_BH4,
        P_RAW, P_TR0, P_TR1, P_TR2, P_TR3
    } phase_t;

    phase_t                      ph_reg, ph_next, ph_step;
    logic                        hs_reg, hs_next;
    logic                        filt_reg, filt_next;
    logic [7:0]                  d_reg, d_next;
    logic [pzsf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RB_W-1:0]             bir_reg, bir_next;
    logic [LW-1:0]               blk_reg, blk_next;
    logic [TOT_W-1:0]            tot_reg, tot_next;
    logic [15:0]                 lo_reg, lo_next;
    logic [15:0]                 hi_reg, hi_next;

    logic                        step_go;
    logic                        emit;
    logic [7:0]                  ob;
    logic                        eos;
    logic [LW-1:0]               len;
    logic [LW-1:0]               nlen;
    logic                        final_blk;
    logic [7:0]                  raw_v;
    logic [16:0]                 lo_sum, hi_sum;
    logic [RB_W:0]               bir_inc;
    logic                        accept;

    assign final_blk = (tot_reg <= TOT_W'(BLOCK_LEN));
    assign len       = final_blk ? tot_reg[LW-1:0] : BLK_MAX;
    assign nlen      = ~len;
    assign raw_v     = filt_reg ? 8'h00 : d_reg;
    assign lo_sum    = {1'b0, lo_reg} + {9'b0, raw_v};
    assign bir_inc   = {1'b0, bir_reg} + (RB_W+1)'(1);
    assign step_go   = (ph_reg != P_IDLE) && space;
    assign emit      = (cnt_reg < pzsf_pkg::MAX_RESULTS);

    always_comb begin
        ph_step   = ph_reg;
        hs_next   = hs_reg;
        filt_next = filt_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        bir_next  = bir_reg;
        blk_next  = blk_reg;
        tot_next  = tot_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        ob        = 8'h00;
        eos       = 1'b0;
        hi_sum    = '0;

        if (step_go) begin
            case (ph_reg)
                P_ZH0: begin
                    ob       = pzsf_pkg::ZLIB_CMF;
                    tot_next = total_bytes;
                    hs_next  = 1'b1;
                    bir_next = '0;
                    blk_next = '0;
                    lo_next  = 16'd1;
                    hi_next  = 16'd0;
                    ph_step  = P_ZH1;
                end
                P_ZH1: begin
                    ob        = pzsf_pkg::ZLIB_FLG;
                    filt_next = 1'b1;
                    ph_step   = (blk_reg == '0) ? P_BH0 : P_RAW;
                end
                P_BH0: begin
                    ob      = {7'b0, final_blk};
                    ph_step = P_BH1;
                end
                P_BH1: begin
                    ob      = len[7:0];
                    ph_step = P_BH2;
                end
                P_BH2: begin
                    ob      = len[15:8];
                    ph_step = P_BH3;
                end
                P_BH3: begin
                    ob      = nlen[7:0];
                    ph_step = P_BH4;
                end
                P_BH4: begin
                    ob       = nlen[15:8];
                    blk_next = len;
                    ph_step  = P_RAW;
                end
                P_RAW: begin
                    ob       = raw_v;
                    lo_next  = (lo_sum >= pzsf_pkg::ADLER_MOD) ?
                               16'(lo_sum - pzsf_pkg::ADLER_MOD) : lo_sum[15:0];
                    hi_sum   = {1'b0, hi_reg} + {1'b0, lo_next};
                    hi_next  = (hi_sum >= pzsf_pkg::ADLER_MOD) ?
                               16'(hi_sum - pzsf_pkg::ADLER_MOD) : hi_sum[15:0];
                    blk_next = blk_reg - LW'(1);
                    tot_next = tot_reg - TOT_W'(1);
                    if (filt_reg) begin
                        // filter byte done, the data byte follows (after a block header if the block is full)
                        filt_next = 1'b0;
                        ph_step   = (blk_next == '0) ? P_BH0 : P_RAW;
                    end else begin
                        bir_next = (bir_inc >= {1'b0, row_len}) ?
                                   '0 : bir_inc[RB_W-1:0];
                        ph_step  = (tot_next == '0) ? P_TR0 : P_IDLE;
                    end
                end
                P_TR0: begin
                    ob      = hi_reg[15:8];
                    ph_step = P_TR1;
                end
                P_TR1: begin
                    ob      = hi_reg[7:0];
                    ph_step = P_TR2;
                end
                P_TR2: begin
                    ob      = lo_reg[15:8];
                    ph_step = P_TR3;
                end
                P_TR3: begin
                    ob      = lo_reg[7:0];
                    eos     = 1'b1;
                    ph_step = P_IDLE;
                end
                default: begin
                    ph_step = P_IDLE;
                end
            endcase
            if (emit) begin
                cnt_next = cnt_reg + pzsf_pkg::CNT_W'(1);
            end
        end

        in_ready = (ph_reg == P_IDLE) || (step_go && ph_step == P_IDLE);
        accept   = in_valid && in_ready;
        ph_next  = ph_step;

        if (accept) begin
            d_next   = in_byte;
            cnt_next = '0;
            if (!hs_next) begin
                ph_next = P_ZH0;
            end else if (tot_next == '0) begin
                // image complete: the item is dropped
                ph_next = P_IDLE;
            end else begin
                filt_next = (bir_next == '0);
                ph_next   = (blk_next == '0) ? P_BH0 : P_RAW;
            end
        end
    end

    assign push          = step_go && emit;
    assign push_res.data = ob;
    assign push_res.eos  = eos;
    assign push_res.last = (ph_step == P_IDLE) ||
                           (cnt_reg == pzsf_pkg::MAX_RESULTS - pzsf_pkg::CNT_W'(1));
    assign frozen        = hs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= P_IDLE;
            hs_reg   <= 1'b0;
            filt_reg <= 1'b0;
            cnt_reg  <= '0;
            bir_reg  <= '0;
            blk_reg  <= '0;
            tot_reg  <= '0;
            lo_reg   <= 16'd1;
            hi_reg   <= 16'd0;
        end else begin
            ph_reg   <= ph_next;
            hs_reg   <= hs_next;
            filt_reg <= filt_next;
            cnt_reg  <= cnt_next;
            bir_reg  <= bir_next;
            blk_reg  <= blk_next;
            tot_reg  <= tot_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
        d_reg <= d_next;
    end

`ifndef SYNTHESIS
    a_hdr_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        hs_reg |=> hs_reg)
        else $error("stream start flag dropped");

    a_raw_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (ph_reg == P_RAW) |-> (blk_reg != '0))
        else $error("raw byte with no stored block open");

    a_eos_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_res.eos) |-> push_res.last)
        else $error("end of stream not on the item's final result");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= pzsf_pkg::MAX_RESULTS)
        else $error("result count beyond limit");
`endif

endmodule
